@@ design/event_time_sorted_queue_core_defines.svh @@
// Assertion macros shared by the sorted event queue RTL.
// No dependencies; included by the controller and datapath files.
`ifndef EVENT_TIME_SORTED_QUEUE_CORE_DEFINES_SVH
`define EVENT_TIME_SORTED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ETSQ_CHECK(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etsq assertion failed");

// Next-cycle implication, disabled during reset.
`define ETSQ_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("etsq assertion failed");

`endif

@@ design/etsq_pkg.sv @@
// Shared types and constants for the sorted event queue.
// No dependencies; imported by controller, datapath and top level.
package etsq_pkg;

   localparam int TIME_W        = 31;
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [TIME_W-1:0] HORIZON_RESET = {TIME_W{1'b1}};

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_POP = 1'b1;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADD_START,
      OP_REJECT,
      OP_POP_EMPTY,
      OP_POP_READ,
      OP_POP_DONE,
      OP_SRCH_READ,
      OP_SRCH_CMP,
      OP_DUP,
      OP_FULL,
      OP_SHIFT_INIT,
      OP_SHIFT_READ,
      OP_SHIFT_WRITE,
      OP_INSERT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic filter_pass;
      logic is_empty;
      logic is_full;
      logic search_done;
      logic dup_found;
      logic shift_done;
   } dp_status_type;

endpackage

@@ design/etsq_ctrl.sv @@
// Controller FSM for the sorted event queue: sequences search, shift and pop.
// Depends on etsq_pkg and the shared assertion macro header.
`include "event_time_sorted_queue_core_defines.svh"

module etsq_ctrl
   import etsq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '{op: OP_NONE, load_rsp: 1'b0};
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_POP) begin
                  if (status.is_empty) begin
                     cmd.op   = OP_POP_EMPTY;
                     state_in = ST_EMIT;
                  end else begin
                     cmd.op   = OP_POP_READ;
                     state_in = ST_POP_WAIT;
                  end
               end else if (status.filter_pass) begin
                  cmd.op   = OP_ADD_START;
                  state_in = ST_SRCH_RD;
               end else begin
                  cmd.op   = OP_REJECT;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_POP_WAIT: begin
            cmd.op   = OP_POP_DONE;
            state_in = ST_EMIT;
         end
         ST_SRCH_RD: begin
            priority if (!status.search_done) begin
               cmd.op   = OP_SRCH_READ;
               state_in = ST_SRCH_CMP;
            end else if (status.dup_found) begin
               cmd.op   = OP_DUP;
               state_in = ST_EMIT;
            end else if (status.is_full) begin
               cmd.op   = OP_FULL;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = OP_SHIFT_INIT;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SRCH_CMP: begin
            cmd.op   = OP_SRCH_CMP;
            state_in = ST_SRCH_RD;
         end
         ST_SHIFT_RD: begin
            if (status.shift_done) begin
               cmd.op   = OP_INSERT;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = OP_SHIFT_READ;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.op   = OP_SHIFT_WRITE;
            state_in = ST_SHIFT_RD;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ETSQ_CHECK(a_load_slot_free, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)
   `ETSQ_CHECK_NEXT(a_load_sets_valid, clock, reset, cmd.load_rsp, rsp_valid_ff)

endmodule

@@ design/etsq_dp.sv @@
// Datapath for the sorted event queue: circular time memory, binary search,
// shift-insert, filter registers and result staging. Depends on etsq_pkg.
`include "event_time_sorted_queue_core_defines.svh"

module etsq_dp
   import etsq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic [TIME_W-1:0] req_offered_time,
   input  logic [TIME_W-1:0] req_current_time,
   input  logic              csr_wr_en,
   input  logic [TIME_W-1:0] csr_wr_data,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   output logic [TIME_W-1:0] rsp_popped_time,
   output logic              rsp_was_empty,
   output logic              rsp_accepted,
   output logic              rsp_dropped_full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 1;

   // time storage, circular, logical 0 at head_ff
   logic [TIME_W-1:0] slot_mem_ff [DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   logic [AW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] horizon_ff;

   logic [TIME_W-1:0] t_ff;
   logic [CW-1:0]     lo_ff, hi_ff, mid_ff, idx_ff;
   logic              dup_ff;

   logic [TIME_W-1:0] res_popped_ff;
   logic              res_empty_ff, res_acc_ff, res_drop_ff;
   logic [TIME_W-1:0] rsp_popped_ff;
   logic              rsp_empty_ff, rsp_acc_ff, rsp_drop_ff;

   logic [PW-1:0]     lohi_sum;
   logic [CW-1:0]     mid;
   logic              mem_re, mem_we;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [TIME_W-1:0] wr_data;
   logic              is_full;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] lidx);
      logic [PW-1:0] sum;
      sum = PW'(head) + PW'(lidx);
      if (sum >= PW'(DEPTH)) begin
         sum = sum - PW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign lohi_sum = PW'(lo_ff) + PW'(hi_ff);
   assign mid      = lohi_sum[CW:1];
   assign is_full  = (count_ff == CW'(DEPTH));

   assign status.filter_pass = (req_offered_time != last_ff)
                             && (req_offered_time > req_current_time)
                             && (req_offered_time <= horizon_ff);
   assign status.is_empty    = (count_ff == '0);
   assign status.is_full     = is_full;
   assign status.search_done = (lo_ff == hi_ff);
   assign status.dup_found   = dup_ff;
   assign status.shift_done  = (idx_ff == lo_ff);

   always_comb begin
      mem_re  = 1'b0;
      rd_addr = head_ff;
      unique case (cmd.op)
         OP_POP_READ: begin
            mem_re = 1'b1;
         end
         OP_SRCH_READ: begin
            mem_re  = 1'b1;
            rd_addr = phys(head_ff, mid);
         end
         OP_SHIFT_READ: begin
            mem_re  = 1'b1;
            rd_addr = phys(head_ff, idx_ff - CW'(1));
         end
         default: mem_re = 1'b0;
      endcase
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = phys(head_ff, idx_ff);
      wr_data = rd_data_ff;
      unique case (cmd.op)
         OP_SHIFT_WRITE: begin
            mem_we = 1'b1;
         end
         OP_INSERT: begin
            mem_we  = 1'b1;
            wr_addr = phys(head_ff, lo_ff);
            wr_data = t_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         last_ff    <= '0;
         horizon_ff <= HORIZON_RESET;
      end else begin
         if (csr_wr_en) begin
            horizon_ff <= csr_wr_data;
         end
         unique case (cmd.op)
            OP_ADD_START: last_ff <= req_offered_time;
            OP_POP_DONE: begin
               head_ff  <= phys(head_ff, CW'(1));
               count_ff <= count_ff - CW'(1);
            end
            OP_INSERT: count_ff <= count_ff + CW'(1);
            default: ;
         endcase
      end
   end

   // working registers and result staging
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ADD_START: begin
            t_ff   <= req_offered_time;
            lo_ff  <= '0;
            hi_ff  <= count_ff;
            dup_ff <= 1'b0;
         end
         OP_SRCH_READ: mid_ff <= mid;
         OP_SRCH_CMP: begin
            if (rd_data_ff < t_ff) begin
               lo_ff <= mid_ff + CW'(1);
            end else begin
               hi_ff <= mid_ff;
            end
            if (rd_data_ff == t_ff) begin
               dup_ff <= 1'b1;
            end
         end
         OP_SHIFT_INIT:  idx_ff <= count_ff;
         OP_SHIFT_WRITE: idx_ff <= idx_ff - CW'(1);
         default: ;
      endcase

      unique case (cmd.op)
         OP_REJECT: begin
            res_popped_ff <= '0;
            res_empty_ff  <= 1'b0;
            res_acc_ff    <= 1'b0;
            res_drop_ff   <= 1'b0;
         end
         OP_POP_EMPTY: begin
            res_popped_ff <= '0;
            res_empty_ff  <= 1'b1;
            res_acc_ff    <= 1'b0;
            res_drop_ff   <= 1'b0;
         end
         OP_POP_DONE: begin
            res_popped_ff <= rd_data_ff;
            res_empty_ff  <= 1'b0;
            res_acc_ff    <= 1'b0;
            res_drop_ff   <= 1'b0;
         end
         OP_DUP, OP_INSERT: begin
            res_popped_ff <= '0;
            res_empty_ff  <= 1'b0;
            res_acc_ff    <= 1'b1;
            res_drop_ff   <= 1'b0;
         end
         OP_FULL: begin
            res_popped_ff <= '0;
            res_empty_ff  <= 1'b0;
            res_acc_ff    <= 1'b0;
            res_drop_ff   <= 1'b1;
         end
         default: ;
      endcase

      if (cmd.load_rsp) begin
         rsp_popped_ff <= res_popped_ff;
         rsp_empty_ff  <= res_empty_ff;
         rsp_acc_ff    <= res_acc_ff;
         rsp_drop_ff   <= res_drop_ff;
      end
   end

   assign rsp_popped_time  = rsp_popped_ff;
   assign rsp_was_empty    = rsp_empty_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_dropped_full = rsp_drop_ff;

   `ETSQ_CHECK(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `ETSQ_CHECK(a_insert_has_room, clock, reset, cmd.op == OP_INSERT, !is_full)
   `ETSQ_CHECK_NEXT(a_pop_decrements, clock, reset, cmd.op == OP_POP_DONE, count_ff == $past(count_ff) - CW'(1))

endmodule

@@ design/event_time_sorted_queue_core.sv @@
// Top level of the sorted event time queue with duplicate suppression.
// Depends on etsq_pkg, etsq_ctrl and etsq_dp.
//
// Channel   Direction  Handshake                  Payload
// req_      in         req_valid / req_ready      kind, offered_time, current_time
// rsp_      out        rsp_valid / rsp_ready      popped_time, was_empty, accepted,
//                                                 dropped_full
// csr_      in         csr_wr_en (no wait)        horizon
//
// Steps: reject and empty pop go straight to the result, a pop reads the head.
//   An add that passes the filter runs s search steps, s <= ceil(log2(n+1))
//   for n stored times; a duplicate or full set then ends, an insert at
//   position p first shifts n - p entries: every search step and every
//   shifted entry goes through the single read and single write port.
// Reset: synchronous, active high; empties the set, clears the last time that
//   passed the filter, sets horizon to all ones. Memory contents are not cleared.
// Stalls: one transaction at a time; the next request is taken while the
//   previous result still waits in the output register, and the block only
//   holds in its final step when that register is still occupied.
module event_time_sorted_queue_core
   import etsq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   // request transactions
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [TIME_W-1:0] req_offered_time,
   input  logic [TIME_W-1:0] req_current_time,
   // response transactions
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [TIME_W-1:0] rsp_popped_time,
   output logic              rsp_was_empty,
   output logic              rsp_accepted,
   output logic              rsp_dropped_full,
   // horizon register write
   input  logic              csr_wr_en,
   input  logic [TIME_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: handshakes, search/shift steps, result hand-off
   etsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, compare logic and result registers
   etsq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_offered_time (req_offered_time),
      .req_current_time (req_current_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_popped_time  (rsp_popped_time),
      .rsp_was_empty    (rsp_was_empty),
      .rsp_accepted     (rsp_accepted),
      .rsp_dropped_full (rsp_dropped_full)
   );

endmodule
